// ----- design/apr_pkg.sv -----
package apr_pkg;

   localparam int DEF_FRAME_COUNT = 16;
   localparam int DEF_PAGE_BITS   = 16;

   localparam int PAGE_NUMBER_W = 16;
   localparam int FRAME_INDEX_W = 4;
   localparam int FAULT_TOTAL_W = 32;
   localparam int AGE_W         = 8;
   localparam int CSR_W         = 5;

   localparam logic [AGE_W-1:0] AGE_TOP   = 8'h80;
   localparam logic [CSR_W-1:0] CSR_RESET = 5'd16;

   // controller to datapath
   typedef struct packed {
      logic start;   // latch the page word, clear the scan results
      logic scan;    // read the frame at the scan address, advance
      logic commit;  // place the page, load the result word
   } apr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;  // scan address is on the last frame
      logic out_stall;  // result word still waits on the sink
   } apr_status_type;

endpackage

// ----- design/apr_ifs.sv -----
interface apr_req_if;
   logic                             valid;
   logic                             ready;
   logic [apr_pkg::PAGE_NUMBER_W-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink (input valid, input page_number, output ready);
endinterface

interface apr_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             fault;
   logic [apr_pkg::FRAME_INDEX_W-1:0] frame_index;
   logic                             evicted_valid;
   logic [apr_pkg::PAGE_NUMBER_W-1:0] evicted_page;
   logic [apr_pkg::FAULT_TOTAL_W-1:0] fault_total;

   modport source (output valid, output fault, output frame_index, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink (input valid, input fault, input frame_index, input evicted_valid,
                 input evicted_page, input fault_total, output ready);
endinterface

interface apr_csr_if;
   logic                     valid;
   logic                     ready;
   logic [apr_pkg::CSR_W-1:0] frames_in_use;

   modport source (output valid, output frames_in_use, input ready);
   modport sink (input valid, input frames_in_use, output ready);
endinterface

// ----- design/aging_page_replacement.sv -----
// Each request word is placed after a frame scan, which reads one frame a cycle through
// the page and age memory port.
// A new request word is taken while the previous response word still waits.
// Reset (synchronous, active high) clears frame valid bits, the fault count and the
// frame limit (to 16); the page and age memories are not cleared.
module aging_page_replacement #(
   parameter int FRAME_COUNT = apr_pkg::DEF_FRAME_COUNT,
   parameter int PAGE_BITS   = apr_pkg::DEF_PAGE_BITS
) (
   input logic      clock,
   input logic      reset,
   apr_req_if.sink  req_bus,
   apr_rsp_if.source rsp_bus,
   apr_csr_if.sink  csr_bus
);
   import apr_pkg::*;

   apr_cmd_type    cmd;
   apr_status_type status;

   assign csr_bus.ready = 1'b1;

   apr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status_in (status),
      .cmd_out   (cmd)
   );

   apr_datapath #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_BITS   (PAGE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd_in            (cmd),
      .status_out        (status),
      .req_page_number   (req_bus.page_number),
      .csr_write         (csr_bus.valid),
      .csr_frames_in_use (csr_bus.frames_in_use),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_fault         (rsp_bus.fault),
      .rsp_frame_index   (rsp_bus.frame_index),
      .rsp_evicted_valid (rsp_bus.evicted_valid),
      .rsp_evicted_page  (rsp_bus.evicted_page),
      .rsp_fault_total   (rsp_bus.fault_total)
   );

endmodule

// ----- design/apr_controller.sv -----
module apr_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  apr_pkg::apr_status_type status_in,
   output apr_pkg::apr_cmd_type    cmd_out
);
   import apr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd_out.start  = 1'b0;
      cmd_out.scan   = 1'b0;
      cmd_out.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd_out.start = req_valid;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd_out.scan = 1'b1;
            if (status_in.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         // last frame read is still in flight
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the previous result word is taken
            cmd_out.commit = !status_in.out_stall;
            if (!status_in.out_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/apr_datapath.sv -----
module apr_datapath #(
   parameter int FRAME_COUNT = apr_pkg::DEF_FRAME_COUNT,
   parameter int PAGE_BITS   = apr_pkg::DEF_PAGE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  apr_pkg::apr_cmd_type              cmd_in,
   output apr_pkg::apr_status_type           status_out,
   input  logic [apr_pkg::PAGE_NUMBER_W-1:0] req_page_number,
   input  logic                              csr_write,
   input  logic [apr_pkg::CSR_W-1:0]         csr_frames_in_use,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_fault,
   output logic [apr_pkg::FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic                              rsp_evicted_valid,
   output logic [apr_pkg::PAGE_NUMBER_W-1:0] rsp_evicted_page,
   output logic [apr_pkg::FAULT_TOTAL_W-1:0] rsp_fault_total
);
   import apr_pkg::*;

   localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int CNT_W = $clog2(FRAME_COUNT + 1);
   localparam int LIM_W = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);
   localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(FRAME_COUNT);

   // configuration
   logic [CSR_W-1:0] limit_cfg_ff;

   // scan control and memories
   logic [PAGE_BITS-1:0] page_ff;
   logic [IDX_W-1:0]     addr_ff;
   logic [IDX_W-1:0]     proc_idx_ff;
   logic                 proc_en_ff;
   logic [PAGE_BITS-1:0] page_mem [FRAME_COUNT];
   logic [AGE_W-1:0]     age_mem [FRAME_COUNT];
   logic [PAGE_BITS-1:0] page_rd_ff;
   logic [AGE_W-1:0]     age_rd_ff;
   logic [FRAME_COUNT-1:0] valid_ff;

   // scan results
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [AGE_W-1:0]     hit_age_ff, hit_age_in;
   logic [CNT_W-1:0]     resident_ff, resident_in;
   logic                 victim_ff, victim_in;
   logic [IDX_W-1:0]     victim_idx_ff, victim_idx_in;
   logic [AGE_W-1:0]     victim_age_ff, victim_age_in;
   logic [PAGE_BITS-1:0] victim_page_ff, victim_page_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;

   // fault count and result word
   logic [FAULT_TOTAL_W-1:0] fault_cnt_ff, fault_cnt_in;
   logic                     rsp_valid_ff;
   logic                     rsp_fault_ff;
   logic [FRAME_INDEX_W-1:0] rsp_frame_index_ff;
   logic                     rsp_evicted_valid_ff;
   logic [PAGE_NUMBER_W-1:0] rsp_evicted_page_ff;

   logic [PAGE_BITS+PAGE_NUMBER_W-1:0]   page_wide;
   logic [PAGE_BITS+PAGE_NUMBER_W-1:0]   evict_wide;
   logic [IDX_W+FRAME_INDEX_W-1:0]       slot_wide;
   logic                 cur_valid;
   logic [AGE_W-1:0]     shifted_age;
   logic [LIM_W-1:0]     cfg_ext;
   logic [LIM_W-1:0]     limit;
   logic                 full;
   logic                 miss;
   logic [IDX_W-1:0]     slot;
   logic [AGE_W-1:0]     new_age;
   logic                 age_we;
   logic [IDX_W-1:0]     age_waddr;
   logic [AGE_W-1:0]     age_wdata;

   assign page_wide   = {{PAGE_NUMBER_W{1'b0}}, req_page_number};
   assign cur_valid   = valid_ff[proc_idx_ff];
   assign shifted_age = age_rd_ff >> 1;

   // walk one frame per cycle: hit search, resident count, oldest, first free
   always_comb begin
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_age_in     = hit_age_ff;
      resident_in    = resident_ff;
      victim_in      = victim_ff;
      victim_idx_in  = victim_idx_ff;
      victim_age_in  = victim_age_ff;
      victim_page_in = victim_page_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      if (cmd_in.start) begin
         hit_in         = 1'b0;
         hit_idx_in     = '0;
         resident_in    = '0;
         victim_in      = 1'b0;
         victim_idx_in  = '0;
         free_in        = 1'b0;
         free_idx_in    = '0;
      end else if (proc_en_ff) begin
         if (cur_valid) begin
            resident_in = resident_ff + CNT_W'(1);
            if (!hit_ff && (page_rd_ff == page_ff)) begin
               hit_in     = 1'b1;
               hit_idx_in = proc_idx_ff;
               hit_age_in = shifted_age;
            end
            // strict compare keeps the lowest index on a tie
            if (!victim_ff || (shifted_age < victim_age_ff)) begin
               victim_in      = 1'b1;
               victim_idx_in  = proc_idx_ff;
               victim_age_in  = shifted_age;
               victim_page_in = page_rd_ff;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = proc_idx_ff;
         end
      end
   end

   // placement decision
   always_comb begin
      cfg_ext = LIM_W'(limit_cfg_ff);
      priority if (cfg_ext == '0) begin
         limit = LIM_W'(1);
      end else if (cfg_ext > LIM_MAX) begin
         limit = LIM_MAX;
      end else begin
         limit = cfg_ext;
      end
      full = LIM_W'(resident_ff) >= limit;
      miss = !hit_ff;
      priority if (hit_ff) begin
         slot = hit_idx_ff;
      end else if (full) begin
         slot = victim_idx_ff;
      end else begin
         slot = free_idx_ff;
      end
      new_age = hit_ff ? (hit_age_ff | AGE_TOP) : AGE_TOP;
      if (cmd_in.commit && miss && (fault_cnt_ff != '1)) begin
         fault_cnt_in = fault_cnt_ff + FAULT_TOTAL_W'(1);
      end else begin
         fault_cnt_in = fault_cnt_ff;
      end
      if (cmd_in.commit) begin
         age_we    = 1'b1;
         age_waddr = slot;
         age_wdata = new_age;
      end else begin
         age_we    = proc_en_ff && cur_valid;
         age_waddr = proc_idx_ff;
         age_wdata = shifted_age;
      end
   end

   assign slot_wide  = {{FRAME_INDEX_W{1'b0}}, slot};
   assign evict_wide = {{PAGE_NUMBER_W{1'b0}}, victim_page_ff};

   always_ff @(posedge clock) begin
      if (cmd_in.scan) begin
         page_rd_ff <= page_mem[addr_ff];
         age_rd_ff  <= age_mem[addr_ff];
      end
      if (age_we) begin
         age_mem[age_waddr] <= age_wdata;
      end
      if (cmd_in.commit && miss) begin
         page_mem[slot] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_in.start) begin
         page_ff <= page_wide[PAGE_BITS-1:0];
      end
      proc_idx_ff    <= addr_ff;
      hit_idx_ff     <= hit_idx_in;
      hit_age_ff     <= hit_age_in;
      resident_ff    <= resident_in;
      victim_idx_ff  <= victim_idx_in;
      victim_age_ff  <= victim_age_in;
      victim_page_ff <= victim_page_in;
      free_idx_ff    <= free_idx_in;
      if (cmd_in.commit) begin
         rsp_fault_ff         <= miss;
         rsp_frame_index_ff   <= slot_wide[FRAME_INDEX_W-1:0];
         rsp_evicted_valid_ff <= miss && full;
         rsp_evicted_page_ff  <= (miss && full) ? evict_wide[PAGE_NUMBER_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_cfg_ff <= CSR_RESET;
         addr_ff      <= '0;
         proc_en_ff   <= 1'b0;
         valid_ff     <= '0;
         hit_ff       <= 1'b0;
         victim_ff    <= 1'b0;
         free_ff      <= 1'b0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            limit_cfg_ff <= csr_frames_in_use;
         end
         if (cmd_in.start) begin
            addr_ff <= '0;
         end else if (cmd_in.scan) begin
            addr_ff <= addr_ff + IDX_W'(1);
         end
         proc_en_ff <= cmd_in.scan;
         if (cmd_in.commit && miss) begin
            valid_ff[slot] <= 1'b1;
         end
         hit_ff       <= hit_in;
         victim_ff    <= victim_in;
         free_ff      <= free_in;
         fault_cnt_ff <= fault_cnt_in;
         if (cmd_in.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status_out.scan_last = (addr_ff == LAST_IDX);
   assign status_out.out_stall = rsp_valid_ff && !rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fault         = rsp_fault_ff;
   assign rsp_frame_index   = rsp_frame_index_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_total   = fault_cnt_ff;

`ifndef SYNTH
   a_commit_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_in.commit |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result word overwritten before it was taken");

   a_free_frame_found: assert property (@(posedge clock) disable iff (reset)
      (cmd_in.commit && miss && !full) |-> free_ff)
      else $error("fill with no free frame seen");

   a_victim_found: assert property (@(posedge clock) disable iff (reset)
      (cmd_in.commit && miss && full) |-> victim_ff)
      else $error("eviction with no resident frame seen");

   a_start_not_scanning: assert property (@(posedge clock) disable iff (reset)
      cmd_in.start |-> (!proc_en_ff && !cmd_in.scan))
      else $error("new word taken during a scan");

   a_fault_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fault_cnt_ff >= $past(fault_cnt_ff)))
      else $error("fault count went down");
`endif

endmodule

// ----- test/page_replacement_checker.sv -----
`timescale 1ns / 100ps

module page_replacement_checker #(
   parameter int FRAME_COUNT = apr_pkg::DEF_FRAME_COUNT
) (
   input  logic clock,
   input  logic reset,
   apr_req_if   req_bus,
   apr_rsp_if   rsp_bus,
   apr_csr_if   csr_bus,
   output int   pending_words,
   output int   mismatch_count
);

   localparam int PW = apr_pkg::PAGE_NUMBER_W;
   localparam int FW = apr_pkg::FRAME_INDEX_W;

   typedef struct packed {
      logic                              fault;
      logic [FW-1:0]                     frame_index;
      logic                              evicted_valid;
      logic [PW-1:0]                     evicted_page;
      logic [apr_pkg::FAULT_TOTAL_W-1:0] fault_total;
   } page_outcome_type;

   logic [PW-1:0]                     frame_page  [FRAME_COUNT];
   logic [apr_pkg::AGE_W-1:0]         frame_age   [FRAME_COUNT];
   logic                              frame_valid [FRAME_COUNT];
   logic [apr_pkg::FAULT_TOTAL_W-1:0] fault_count;
   logic [apr_pkg::CSR_W-1:0]         frames_limit;
   page_outcome_type                  expected_outcomes [$];

   // age every resident frame, then look up and place the page
   function automatic page_outcome_type age_and_place(logic [PW-1:0] page);
      page_outcome_type outcome;
      int            i;
      int            hit_at;
      int            slot;
      int            victim;
      int            resident;
      int            usable;
      outcome  = '0;
      hit_at   = -1;
      resident = 0;
      for (i = 0; i < FRAME_COUNT; i++) begin
         if (frame_valid[i]) begin
            frame_age[i] = frame_age[i] >> 1;
            resident++;
            if (hit_at < 0 && frame_page[i] == page)
               hit_at = i;
         end
      end
      usable = int'(frames_limit);
      if (usable < 1)
         usable = 1;
      if (usable > FRAME_COUNT)
         usable = FRAME_COUNT;
      if (hit_at >= 0) begin
         slot = hit_at;
      end else begin
         outcome.fault = 1'b1;
         if (fault_count != '1)
            fault_count++;
         if (resident >= usable) begin
            // smallest age goes, lowest index on a tie
            victim = -1;
            for (i = 0; i < FRAME_COUNT; i++) begin
               if (frame_valid[i] && (victim < 0 || frame_age[i] < frame_age[victim]))
                  victim = i;
            end
            if (victim < 0)
               victim = 0;
            outcome.evicted_valid = 1'b1;
            outcome.evicted_page  = frame_page[victim];
            slot = victim;
         end else begin
            slot = 0;
            for (i = FRAME_COUNT - 1; i >= 0; i--) begin
               if (!frame_valid[i])
                  slot = i;
            end
         end
         frame_page[slot]  = page;
         frame_valid[slot] = 1'b1;
         frame_age[slot]   = '0;
      end
      frame_age[slot]     = frame_age[slot] | apr_pkg::AGE_TOP;
      outcome.frame_index = FW'(slot);
      outcome.fault_total = fault_count;
      return outcome;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      page_outcome_type want;
      if (reset) begin
         for (int i = 0; i < FRAME_COUNT; i++) begin
            frame_valid[i] = 1'b0;
            frame_age[i]   = '0;
         end
         fault_count    = '0;
         frames_limit   = apr_pkg::CSR_RESET;
         mismatch_count = 0;
         expected_outcomes.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no word, got frame %0h fault %b total %0h",
                        $time, rsp_bus.frame_index, rsp_bus.fault, rsp_bus.fault_total);
            end else begin
               want = expected_outcomes.pop_front();
               check_field("fault", 32'(want.fault), 32'(rsp_bus.fault));
               check_field("frame_index", 32'(want.frame_index), 32'(rsp_bus.frame_index));
               check_field("evicted_valid", 32'(want.evicted_valid),
                           32'(rsp_bus.evicted_valid));
               check_field("evicted_page", 32'(want.evicted_page),
                           32'(rsp_bus.evicted_page));
               check_field("fault_total", want.fault_total, rsp_bus.fault_total);
            end
         end
         if (csr_bus.valid && csr_bus.ready)
            frames_limit = csr_bus.frames_in_use;
         if (req_bus.valid && req_bus.ready)
            expected_outcomes.insert(expected_outcomes.size(),
                                     age_and_place(req_bus.page_number));
      end
      pending_words = expected_outcomes.size();
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   localparam int FRAME_COUNT      = apr_pkg::DEF_FRAME_COUNT;
   localparam int QUIET_LIMIT      = 5000;
   localparam int RECV_HOLD_CYCLES = 300;
   localparam int SEGMENTS         = 8;
   localparam int SEGMENT_WORDS    = 100;
   localparam int POOL_MAX         = 32;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   pending_words;
   int   mismatch_count;
   int   send_idle_pct = 28;
   int   recv_idle_pct = 45;
   int   hold_asked = 0;
   int   hold_served = 0;
   logic [apr_pkg::PAGE_NUMBER_W-1:0] page_pool [POOL_MAX];

   apr_req_if req_bus ();
   apr_rsp_if rsp_bus ();
   apr_csr_if csr_bus ();

   aging_page_replacement dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   page_replacement_checker #(.FRAME_COUNT(FRAME_COUNT)) replacement_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .pending_words  (pending_words),
      .mismatch_count (mismatch_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_page(input logic [apr_pkg::PAGE_NUMBER_W-1:0] page);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.page_number <= page;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // drop valid and hold until every word has come back
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_words != 0)
         @(negedge clock);
   endtask

   task automatic write_limit(input logic [apr_pkg::CSR_W-1:0] limit);
      drain();
      csr_bus.valid         <= 1'b1;
      csr_bus.frames_in_use <= limit;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            rsp_bus.ready <= 1'b0;
            repeat (RECV_HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin : quiet_watch
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("aging_page_replacement: mismatch");
      $finish;
   end

   initial begin : stimulus
      int seg;
      int word;
      int i;
      int pool_size;
      logic [apr_pkg::CSR_W-1:0] seg_limit;
      req_bus.valid         <= 1'b0;
      req_bus.page_number   <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.frames_in_use <= '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      send_page(16'hAAAA);
      send_page(16'h5555);
      // limit below the resident count: every miss evicts
      write_limit(5'd2);
      send_page(16'h1234);
      send_page(16'h1234);
      send_page(16'h0000);
      send_page(16'hAAAA);
      // zero acts as one frame
      write_limit(5'd0);
      send_page(16'h8001);
      send_page(16'h7FFE);
      // above the frame count clips to all frames; fill, then evict
      write_limit(5'd31);
      for (i = 0; i < 14; i++)
         send_page(16'(16'h0100 + i));

      for (seg = 0; seg < SEGMENTS; seg++) begin
         case (seg)
            0:       seg_limit = 5'd1;
            1:       seg_limit = 5'd16;
            2, 6:    seg_limit = 5'($urandom_range(2, 15));
            3:       seg_limit = 5'd0;
            4:       seg_limit = 5'd31;
            5:       seg_limit = 5'($urandom_range(17, 30));
            default: seg_limit = 5'd16;
         endcase
         if (seg < 3) begin
            send_idle_pct = 28;
            recv_idle_pct = 45;
         end else if (seg < 6) begin
            send_idle_pct = 45;
            recv_idle_pct = 28;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_limit(seg_limit);
         // a small working set gives hits, a large one evictions
         pool_size = $urandom_range(1, POOL_MAX);
         for (i = 0; i < pool_size; i++)
            page_pool[i] = 16'($urandom_range(65535));
         for (word = 0; word < SEGMENT_WORDS; word++) begin
            if (seg == 1 && word == SEGMENT_WORDS / 2)
               hold_asked++;
            if (seg == 4 && word == SEGMENT_WORDS / 2)
               drain();
            if ($urandom_range(99) < 85)
               send_page(page_pool[5'($urandom_range(pool_size - 1))]);
            else
               send_page(16'($urandom_range(65535)));
         end
      end

      drain();
      repeat (2 * FRAME_COUNT + 8) @(posedge clock);
      if (mismatch_count == 0 && pending_words == 0)
         $display("aging_page_replacement: match");
      else
         $display("aging_page_replacement: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
design/apr_pkg.sv
design/apr_ifs.sv
design/apr_controller.sv
design/apr_datapath.sv
design/aging_page_replacement.sv
test/page_replacement_checker.sv
test/testbench.sv
